FILE: rtl/core/skt_pkg.sv
// types and constants shared by the sorted key table core
// depends on nothing
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KEY_W         = 64;
  localparam int OWN_W         = 4;
  localparam int POS_W         = 7;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [OWN_W-1:0] owner_in;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [OWN_W-1:0] owner_out;
    logic [POS_W-1:0] position;
    logic [1:0]       status;
  } rsp_t;

  // per cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

FILE: rtl/core/sorted_key_table_core.sv
// sorted key table: row of TABLE_DEPTH cells with compare, encode and shift
// each request runs from accept to done strobe through key latch, compare in
// every cell, position encode, then a parallel shift of the row
// a new request is accepted only while idle, after the compare/encode/shift sequence of the last one
// rst clears the entry count and control; slot contents stay undefined until written
// the done strobe lasts one cycle and cannot be held off
// depends on skt_pkg, skt_cell, skt_encode
`timescale 1ns / 1ps

module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_FIND  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state, state_next;

  req_t             req_q;
  logic [IDX_W-1:0] count;
  cell_ctl_t        ctl;

  logic [TABLE_DEPTH-1:0]            lt;
  logic [TABLE_DEPTH-1:0]            eq;
  logic [TABLE_DEPTH-1:0][KEY_W-1:0] slot_keys;
  logic [TABLE_DEPTH-1:0][OWN_W-1:0] slot_owners;

  logic [IDX_W-1:0] pos;
  logic             hit;
  logic [OWN_W-1:0] hit_owner;
  logic             full;
  logic             ins_ok;
  logic             rem_ok;
  logic [1:0]       status_next;

  assign busy   = state != S_IDLE;
  assign full   = count == IDX_W'(TABLE_DEPTH);
  assign ins_ok = (req_q.kind == KIND_INSERT) && !hit && !full;
  assign rem_ok = (req_q.kind == KIND_REMOVE) && hit;

  always_comb begin
    ctl.cmp = state == S_CMP;
    ctl.ins = (state == S_APPLY) && ins_ok;
    ctl.rem = (state == S_APPLY) && rem_ok;
  end

  always_comb begin
    case (req_q.kind)
      KIND_INSERT: status_next = hit ? ST_DUP : (full ? ST_FULL : ST_OK);
      default:     status_next = hit ? ST_OK : ST_MISSING;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CMP;
      S_CMP:   state_next = S_FIND;
      S_FIND:  state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_APPLY;
      if (ctl.ins) begin
        count <= count + 1'b1;
      end else if (ctl.rem) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_q <= req;
    end
    if (state == S_APPLY) begin
      rsp.found     <= hit;
      rsp.owner_out <= hit_owner;
      rsp.position  <= POS_W'(pos);
      rsp.status    <= status_next;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] up_key;
    logic [OWN_W-1:0] up_owner;
    logic [KEY_W-1:0] dn_key;
    logic [OWN_W-1:0] dn_owner;

    if (i == 0) begin : g_first
      assign up_key   = '0;
      assign up_owner = '0;
    end else begin : g_mid
      assign up_key   = slot_keys[i-1];
      assign up_owner = slot_owners[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign dn_key   = slot_keys[i];
      assign dn_owner = slot_owners[i];
    end else begin : g_inner
      assign dn_key   = slot_keys[i+1];
      assign dn_owner = slot_owners[i+1];
    end

    skt_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (req_q.key),
      .owner_new  (req_q.owner_in),
      .pos        (pos),
      .count      (count),
      .up_key     (up_key),
      .up_owner   (up_owner),
      .dn_key     (dn_key),
      .dn_owner   (dn_owner),
      .slot_key   (slot_keys[i]),
      .slot_owner (slot_owners[i]),
      .lt         (lt[i]),
      .eq         (eq[i])
    );
  end

  skt_encode #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_encode (
    .clk    (clk),
    .en     (state == S_FIND),
    .lt     (lt),
    .eq     (eq),
    .owners (slot_owners),
    .pos    (pos),
    .hit    (hit),
    .owner  (hit_owner)
  );

endmodule

FILE: rtl/core/skt_cell.sv
// one table slot: holds a key and its owner, compares against the broadcast key
// and shifts toward either neighbor; depends on skt_pkg
`timescale 1ns / 1ps

module skt_cell
  import skt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 7
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] key,
  input  logic [OWN_W-1:0] owner_new,
  input  logic [IDX_W-1:0] pos,
  input  logic [IDX_W-1:0] count,
  input  logic [KEY_W-1:0] up_key,
  input  logic [OWN_W-1:0] up_owner,
  input  logic [KEY_W-1:0] dn_key,
  input  logic [OWN_W-1:0] dn_owner,
  output logic [KEY_W-1:0] slot_key,
  output logic [OWN_W-1:0] slot_owner,
  output logic             lt,
  output logic             eq
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic valid;

  assign valid = MY_IDX < count;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= valid && (slot_key < key);
      eq <= valid && (slot_key == key);
    end
  end

  // insert: slots above the gap take the lower neighbor, the gap takes the new word
  // remove: slots from the gap upward take the upper neighbor
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX > pos) begin
        slot_key   <= up_key;
        slot_owner <= up_owner;
      end else if (MY_IDX == pos) begin
        slot_key   <= key;
        slot_owner <= owner_new;
      end
    end else if (ctl.rem) begin
      if (MY_IDX >= pos) begin
        slot_key   <= dn_key;
        slot_owner <= dn_owner;
      end
    end
  end

endmodule

FILE: rtl/core/skt_encode.sv
// turns the per-cell compare flags into position, hit and stored owner
// depends on skt_pkg
`timescale 1ns / 1ps

module skt_encode
  import skt_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int IDX_W = 7
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [DEPTH-1:0]            lt,
  input  logic [DEPTH-1:0]            eq,
  input  logic [DEPTH-1:0][OWN_W-1:0] owners,
  output logic [IDX_W-1:0]            pos,
  output logic                        hit,
  output logic [OWN_W-1:0]            owner
);

  logic [IDX_W-1:0] pos_next;
  logic             hit_next;
  logic [OWN_W-1:0] owner_next;

  // lt flags form a thermometer, the first cell not below the key is the position
  always_comb begin
    pos_next   = '0;
    hit_next   = 1'b0;
    owner_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!lt[i] && (i == 0 || lt[(i == 0) ? 0 : i - 1])) begin
        pos_next = pos_next | IDX_W'(i);
      end
      if (eq[i]) begin
        owner_next = owner_next | owners[i];
      end
      hit_next = hit_next | eq[i];
    end
    if (lt[DEPTH-1]) begin
      pos_next = IDX_W'(DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos   <= pos_next;
      hit   <= hit_next;
      owner <= owner_next;
    end
  end

endmodule

FILE: rtl/core/skt_checker.sv
// port-level timing checks for the sorted key table core, bound to the top level
// depends on sorted_key_table_core
`timescale 1ns / 1ps

module skt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // reset leaves the core idle with no strobe pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("core not idle after reset");

  // an accepted word keeps the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("core not busy after accept");

  // fixed latency from accept to done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done)
    else $error("done strobe missing four cycles after accept");

  // strobe is a single cycle and only while idle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("done strobe longer than one cycle or while busy");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

FILE: bench/tb_top.sv
// self-checking bench for sorted_key_table_core: lookup, insert and remove words
// against a sorted-array predictor, random sender gaps, checks each result word
// depends on skt_pkg and sorted_key_table_core
`timescale 1ns / 1ps

module tb_top;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 430;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  sorted_key_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   gap_pct = 0;
  int   n_fail = 0;
  int   cycle_cnt = 0;

  // predicted table contents
  logic [KEY_W-1:0] tab_keys[TABLE_DEPTH];
  logic [OWN_W-1:0] tab_owners[TABLE_DEPTH];
  int               tab_count = 0;

  // key set the generator believes is stored, used to steer hits
  logic [KEY_W-1:0] live_keys[$];

  function automatic rsp_t table_update(req_t r);
    rsp_t res;
    int lo, hi, mid;
    bit hit;
    lo = 0;
    hi = tab_count;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (r.key < tab_keys[mid]) hi = mid;
      else if (tab_keys[mid] < r.key) lo = mid + 1;
      else begin
        hit = 1'b1;
        lo = mid;
      end
    end
    res = '0;
    res.position = POS_W'(lo);
    if (hit) begin
      res.found = 1'b1;
      res.owner_out = tab_owners[lo];
    end
    case (r.kind)
      KIND_INSERT: begin
        if (hit) res.status = ST_DUP;
        else if (tab_count >= TABLE_DEPTH) res.status = ST_FULL;
        else begin
          for (int i = tab_count; i > lo; i--) begin
            tab_keys[i] = tab_keys[i-1];
            tab_owners[i] = tab_owners[i-1];
          end
          tab_keys[lo] = r.key;
          tab_owners[lo] = r.owner_in;
          tab_count++;
          res.status = ST_OK;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          for (int i = lo; i + 1 < tab_count; i++) begin
            tab_keys[i] = tab_keys[i+1];
            tab_owners[i] = tab_owners[i+1];
          end
          tab_count--;
          res.status = ST_OK;
        end else begin
          res.status = ST_MISSING;
        end
      end
      // the unused kind behaves as a lookup
      default: res.status = hit ? ST_OK : ST_MISSING;
    endcase
    return res;
  endfunction

  function automatic int live_index(logic [KEY_W-1:0] k);
    for (int i = 0; i < live_keys.size(); i++)
      if (live_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    logic [KEY_W-1:0] k;
    int r;
    r = $urandom_range(99);
    if (live_keys.size() != 0 && r < hit_pct) begin
      k = live_keys[$urandom_range(live_keys.size() - 1)];
    end else begin
      r = $urandom_range(99);
      if (r < 15) begin
        case ($urandom_range(3))
          0: k = '0;
          1: k = '1;
          2: k = 64'd1;
          default: k = ~64'd1;
        endcase
      end else if (r < 40 && live_keys.size() != 0) begin
        // near miss next to a stored key
        k = live_keys[$urandom_range(live_keys.size() - 1)];
        k = $urandom_range(1) ? k + 64'd1 : k - 64'd1;
      end else begin
        k = {$urandom, $urandom};
      end
    end
    return k;
  endfunction

  task automatic add_item(logic [1:0] kind, logic [KEY_W-1:0] key, logic [OWN_W-1:0] owner);
    req_t r;
    int idx;
    r.kind = kind;
    r.key = key;
    r.owner_in = owner;
    pending_reqs.push_back(r);
    idx = live_index(key);
    if (kind == KIND_INSERT && idx < 0 && live_keys.size() < TABLE_DEPTH)
      live_keys.push_back(key);
    else if (kind == KIND_REMOVE && idx >= 0)
      live_keys.delete(idx);
  endtask

  task automatic add_random(burst_t mode);
    int r, p_ins, p_look, p_rem, hit_pct;
    logic [1:0] kind;
    case (mode)
      BURST_FILL: begin
        p_ins = 75; p_look = 15; p_rem = 7;
      end
      BURST_DRAIN: begin
        p_ins = 8; p_look = 14; p_rem = 75;
      end
      default: begin
        p_ins = 35; p_look = 35; p_rem = 27;
      end
    endcase
    r = $urandom_range(99);
    if (r < p_ins) begin
      kind = KIND_INSERT;
      hit_pct = (mode == BURST_FILL) ? 10 : 30;
    end else if (r < p_ins + p_look) begin
      kind = KIND_LOOKUP;
      hit_pct = 60;
    end else if (r < p_ins + p_look + p_rem) begin
      kind = KIND_REMOVE;
      hit_pct = (mode == BURST_DRAIN) ? 90 : 50;
    end else begin
      kind = KIND_UNUSED;
      hit_pct = 50;
    end
    add_item(kind, pick_key(hit_pct), OWN_W'($urandom_range(15)));
  endtask

  task automatic add_phase(int n_items);
    int n, len, r;
    burst_t mode;
    n = 0;
    while (n < n_items) begin
      r = $urandom_range(99);
      mode = (r < 45) ? BURST_FILL : (r < 75) ? BURST_DRAIN : BURST_MIXED;
      len = $urandom_range(40, 150);
      if (len > n_items - n) len = n_items - n;
      repeat (len) add_random(mode);
      n += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(negedge clk);
  endtask

  initial begin
    gap_pct = 28;
    // empty table
    add_item(KIND_LOOKUP, '0, 4'd3);
    add_item(KIND_REMOVE, '1, 4'd0);
    add_item(KIND_UNUSED, 64'd5, 4'd15);
    // inserts, a duplicate, lookups and removes of extreme, middle and pattern keys
    add_item(KIND_INSERT, '1, 4'd15);
    add_item(KIND_INSERT, '0, 4'd0);
    add_item(KIND_INSERT, 64'h8000_0000_0000_0000, 4'd9);
    add_item(KIND_INSERT, 64'h5555_5555_5555_5555, 4'd10);
    add_item(KIND_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 4'd5);
    add_item(KIND_INSERT, '0, 4'd5);
    add_item(KIND_LOOKUP, '1, 4'd0);
    add_item(KIND_LOOKUP, '0, 4'd0);
    add_item(KIND_LOOKUP, 64'd1, 4'd0);
    add_item(KIND_UNUSED, '1, 4'd0);
    add_item(KIND_REMOVE, 64'h8000_0000_0000_0000, 4'd0);
    add_item(KIND_REMOVE, 64'h8000_0000_0000_0000, 4'd0);
    add_item(KIND_LOOKUP, 64'h8000_0000_0000_0000, 4'd0);
    add_item(KIND_INSERT, ~64'd1, 4'd6);
    add_item(KIND_REMOVE, '1, 4'd0);
    add_item(KIND_REMOVE, '0, 4'd0);
    add_item(KIND_REMOVE, ~64'd1, 4'd0);
    add_item(KIND_REMOVE, 64'h5555_5555_5555_5555, 4'd0);
    add_item(KIND_REMOVE, 64'haaaa_aaaa_aaaa_aaaa, 4'd0);
    add_item(KIND_LOOKUP, 64'h5555_5555_5555_5555, 4'd0);
    add_phase(PHASE_ITEMS);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait_drained();
    gap_pct = 67;
    add_phase(PHASE_ITEMS);
    wait_drained();
    gap_pct = 0;
    add_phase(PHASE_ITEMS);
    wait_drained();
    repeat (20) @(posedge clk);
    if (n_fail == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // sender: holds each word until accepted, gaps only between words
  always @(posedge clk) begin
    bit accepted;
    accepted = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted) begin
        expected_rsps.push_back(table_update(req));
        pending_reqs.pop_front();
      end
      if (accepted || !start) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          req <= pending_reqs[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("result word with none expected: %p", rsp);
        n_fail++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, rsp.found);
          n_fail++;
        end
        if (rsp.owner_out !== want.owner_out) begin
          $error("owner_out: expected %0d, actual %0d", want.owner_out, rsp.owner_out);
          n_fail++;
        end
        if (rsp.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, rsp.position);
          n_fail++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
